@@ src/lcis_pkg.sv @@
// Package for the longest common increasing subsequence engine.
// Holds the item structs, request and result codes and the sequencer states.
// No dependencies.
package lcis_pkg;

  // Default capacity of each loaded sequence.
  localparam int MAX_LEN_DEF = 32;
  // Width of one length table entry.
  localparam int LEN_W = 6;

  typedef enum logic [1:0] {
    REQ_APPEND_FIRST  = 2'd0,
    REQ_APPEND_SECOND = 2'd1,
    REQ_RUN           = 2'd2
  } req_type_t;

  typedef enum logic {
    KIND_LENGTH  = 1'b0,
    KIND_ELEMENT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value_res;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_LEN_RD,
    ST_LEN_LAT,
    ST_TB_CHK,
    ST_TB_A,
    ST_TB_B,
    ST_TB_SRCH,
    ST_EMIT_LEN,
    ST_EMIT_ELEM
  } state_t;

endpackage

@@ src/lcis_length_and_traceback.sv @@
// Top level of the longest common increasing subsequence engine.
// Loads two sequences, fills the length table, traces back and emits results.
// Depends on lcis_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in_     | input     | in_valid / in_ready  | in_item_t  {req_type, value}
//   out_    | output    | out_valid / out_ready| out_item_t {kind, value_res, last}
//
// An append item is stored while the sequencer stays idle. During a run every
// table cell needs a registered read of the cell above (ST_FILL_RD) and then a
// write (ST_FILL_WR). Each traceback row step passes ST_TB_CHK, ST_TB_A and
// ST_TB_B, with a search for a match in ST_TB_SRCH where needed, and the
// emission loads one result into the output register whenever it is free.
// Reset (rst_n, synchronous, active low) clears the sequencer, both element
// counts and the output valid flag; the table needs no clearing pass.
// A stalled output holds its item in the output register; the sequencer waits
// for it to be taken before loading the next result of the same run.
module lcis_length_and_traceback #(
  parameter int MAX_LEN = lcis_pkg::MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcis_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcis_pkg::out_item_t out_data
);
  import lcis_pkg::*;

  // Count width holds 0..MAX_LEN; column width holds 0..MAX_LEN+1.
  localparam int CW     = $clog2(MAX_LEN + 1);
  localparam int JW     = $clog2(MAX_LEN + 2);
  localparam int IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int COLS   = MAX_LEN + 2;
  localparam int TDEPTH = (MAX_LEN + 1) * COLS;
  localparam int AW     = $clog2(TDEPTH);

  // Control state.
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt1_r, cnt1_nxt;
  logic [CW-1:0] cnt2_r, cnt2_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [CW-1:0]    row_r, row_nxt;
  logic [JW-1:0]    col_r, col_nxt;
  logic [JW-1:0]    k_r, k_nxt;
  logic [LEN_W-1:0] kval_r, kval_nxt;
  logic [LEN_W-1:0] cur_r, cur_nxt;
  logic [CW-1:0]    len_r, len_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    eidx_r, eidx_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // Element stores and answer buffer.
  logic signed [31:0] seq1_mem [MAX_LEN];
  logic signed [31:0] seq2_mem [MAX_LEN];
  logic signed [31:0] ans_mem  [MAX_LEN];
  logic               seq1_we, seq2_we, ans_we;
  logic [IW-1:0]      ans_waddr;

  // Length table memory with a registered read port.
  logic [LEN_W-1:0] tbl_mem [TDEPTH];
  logic [LEN_W-1:0] rd_data_r;
  logic             rd_zero_r;
  logic [CW-1:0]    rd_row;
  logic [JW-1:0]    rd_col;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [LEN_W-1:0] wr_data;

  // Shared element reads and the compare unit.
  logic signed [31:0] ai_r;
  logic signed [31:0] sj_r;
  logic signed [31:0] ans_rd_r;
  logic [JW-1:0]      s_idx_nxt;
  logic [JW-1:0]      sent_col;
  logic               sentinel;
  logic               below;
  logic [LEN_W-1:0]   up_len;
  logic [LEN_W-1:0]   cand;
  logic               out_free;
  logic               in_fire;
  logic               elem_last;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // The sentinel column sits just past the last loaded second element.
  assign sent_col = JW'(cnt2_r) + JW'(1);
  assign sentinel = (col_r == sent_col);

  // The element reads are registered and addressed with the next row and
  // column, so ai_r always holds first[row-1] and sj_r holds second[k-1]
  // during a search step and second[col-1] otherwise.
  assign s_idx_nxt = (state_nxt == ST_TB_SRCH) ? (k_nxt - JW'(1)) : (col_nxt - JW'(1));
  assign below     = sentinel || (ai_r < sj_r);
  assign up_len    = rd_zero_r ? '0 : rd_data_r;
  assign cand      = kval_r + LEN_W'(1);

  assign elem_last = (({1'b0, eidx_r} + (CW+1)'(1)) == {1'b0, len_r});

  // Table read address, one cell per cycle. Row zero always reads as zero.
  always_comb begin
    rd_row = row_r;
    rd_col = col_r;
    case (state_r)
      ST_LEN_RD: begin
        rd_row = cnt1_r;
        rd_col = sent_col;
      end
      ST_FILL_RD, ST_TB_A: begin
        rd_row = row_r - CW'(1);
      end
      default: begin
        rd_row = row_r;
      end
    endcase
  end

  assign rd_addr = AW'(AW'(rd_row) * AW'(COLS)) + AW'(rd_col);
  assign wr_addr = AW'(AW'(row_r) * AW'(COLS)) + AW'(col_r);
  assign wr_en   = (state_r == ST_FILL_WR);
  assign wr_data = (below && (k_r != '0) && (cand > up_len)) ? cand : up_len;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.req_type == REQ_RUN)) begin
          state_nxt = (cnt1_r == '0) ? ST_LEN_RD : ST_FILL_RD;
        end
      end
      ST_FILL_RD: begin
        state_nxt = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        if (sentinel && (row_r == cnt1_r)) begin
          state_nxt = ST_LEN_RD;
        end else begin
          state_nxt = ST_FILL_RD;
        end
      end
      ST_LEN_RD: begin
        state_nxt = ST_LEN_LAT;
      end
      ST_LEN_LAT: begin
        state_nxt = ST_TB_CHK;
      end
      ST_TB_CHK: begin
        state_nxt = (row_r == '0) ? ST_EMIT_LEN : ST_TB_A;
      end
      ST_TB_A: begin
        state_nxt = (rd_data_r == '0) ? ST_EMIT_LEN : ST_TB_B;
      end
      ST_TB_B: begin
        state_nxt = (cur_r == up_len) ? ST_TB_CHK : ST_TB_SRCH;
      end
      ST_TB_SRCH: begin
        if ((k_r != '0) && (sj_r != ai_r)) begin
          state_nxt = ST_TB_SRCH;
        end else if ((k_r == '0) || (pos_r == '0)) begin
          state_nxt = ST_EMIT_LEN;
        end else begin
          state_nxt = ST_TB_CHK;
        end
      end
      ST_EMIT_LEN: begin
        if (out_free) begin
          state_nxt = (len_r == '0) ? ST_IDLE : ST_EMIT_ELEM;
        end
      end
      ST_EMIT_ELEM: begin
        if (out_free && elem_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and output values.
  always_comb begin
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    k_nxt         = k_r;
    kval_nxt      = kval_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    eidx_nxt      = eidx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    seq1_we       = 1'b0;
    seq2_we       = 1'b0;
    ans_we        = 1'b0;
    ans_waddr     = IW'(pos_r - CW'(1));
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.req_type)
            REQ_APPEND_FIRST: begin
              if (cnt1_r < CW'(MAX_LEN)) begin
                seq1_we  = 1'b1;
                cnt1_nxt = cnt1_r + CW'(1);
              end
            end
            REQ_APPEND_SECOND: begin
              if (cnt2_r < CW'(MAX_LEN)) begin
                seq2_we  = 1'b1;
                cnt2_nxt = cnt2_r + CW'(1);
              end
            end
            REQ_RUN: begin
              row_nxt = CW'(1);
              col_nxt = JW'(1);
              k_nxt   = '0;
            end
            default: begin
              row_nxt = row_r;
            end
          endcase
        end
      end
      ST_FILL_WR: begin
        // Remember the latest matching column and the length above it.
        if (!sentinel && (sj_r == ai_r)) begin
          k_nxt    = col_r;
          kval_nxt = up_len;
        end
        if (sentinel) begin
          row_nxt = row_r + CW'(1);
          col_nxt = JW'(1);
          k_nxt   = '0;
        end else begin
          col_nxt = col_r + JW'(1);
        end
      end
      ST_LEN_LAT: begin
        if ({1'b0, up_len} > (LEN_W+1)'(MAX_LEN)) begin
          len_nxt = CW'(MAX_LEN);
          pos_nxt = CW'(MAX_LEN);
        end else begin
          len_nxt = CW'(up_len);
          pos_nxt = CW'(up_len);
        end
        row_nxt = cnt1_r;
        col_nxt = sent_col;
      end
      ST_TB_A: begin
        cur_nxt = rd_data_r;
      end
      ST_TB_B: begin
        if (cur_r == up_len) begin
          row_nxt = row_r - CW'(1);
        end else begin
          k_nxt = col_r - JW'(1);
        end
      end
      ST_TB_SRCH: begin
        if ((k_r != '0) && (sj_r != ai_r)) begin
          k_nxt = k_r - JW'(1);
        end else if ((k_r != '0) && (pos_r != '0)) begin
          ans_we  = 1'b1;
          pos_nxt = pos_r - CW'(1);
          row_nxt = row_r - CW'(1);
          col_nxt = k_r;
        end
      end
      ST_EMIT_LEN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_LENGTH;
          out_data_nxt.value_res = 32'(len_r);
          out_data_nxt.last      = (len_r == '0);
          eidx_nxt               = '0;
          if (len_r == '0) begin
            cnt1_nxt = '0;
            cnt2_nxt = '0;
          end
        end
      end
      ST_EMIT_ELEM: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.kind      = KIND_ELEMENT;
          out_data_nxt.value_res = ans_rd_r;
          out_data_nxt.last      = elem_last;
          eidx_nxt               = eidx_r + CW'(1);
          if (elem_last) begin
            cnt1_nxt = '0;
            cnt2_nxt = '0;
          end
        end
      end
      default: begin
        row_nxt = row_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    kval_r     <= kval_nxt;
    cur_r      <= cur_nxt;
    len_r      <= len_nxt;
    pos_r      <= pos_nxt;
    eidx_r     <= eidx_nxt;
    out_data_r <= out_data_nxt;
  end

  // Element stores, each with one registered read.
  always_ff @(posedge clk) begin
    if (seq1_we) begin
      seq1_mem[cnt1_r[IW-1:0]] <= in_data.value;
    end
    if (seq2_we) begin
      seq2_mem[cnt2_r[IW-1:0]] <= in_data.value;
    end
    if (ans_we) begin
      ans_mem[ans_waddr] <= ai_r;
    end
    ai_r     <= seq1_mem[IW'(row_nxt - CW'(1))];
    sj_r     <= seq2_mem[s_idx_nxt[IW-1:0]];
    ans_rd_r <= ans_mem[IW'(eidx_nxt)];
  end

  // Length table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= tbl_mem[rd_addr];
    rd_zero_r <= (rd_row == '0);
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lcis_length_and_traceback, the LCIS engine.
// Drives load and run items, predicts every result and compares it. Needs lcis_pkg.
module tb;
  import lcis_pkg::*;

  // The block is built at its default capacity, and the predictor follows it.
  localparam int MAX_LEN = MAX_LEN_DEF;
  // A request code that the block has no use for. It must be ignored.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Size of the random part, counted in items that the block does not ignore.
  localparam int RAND_ITEMS = 180;
  // The last stretch of the random part runs with no idling on either side.
  localparam int CALM_ITEMS = 40;
  // The long receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES = 1200;
  // Quiet cycles after the last result, so that a stray extra result shows up.
  localparam int DRAIN_CYCLES = 200;
  // Watchdog limit on the length of the whole simulation.
  localparam int LIMIT = 1_000_000;
  localparam int REPORT_MAX = 10;

  // How the element values of one random load sequence are drawn.
  localparam int MODE_NARROW = 0;   // 0..7, many equal values
  localparam int MODE_SIGNED = 1;   // -4..4, across zero
  localparam int MODE_FULL = 2;     // any 32-bit pattern
  localparam int MODE_EXTREME = 3;  // the extremes, zero, minus one or 0..3
  localparam int MODE_RAMP = 4;     // strictly increasing on both sides

  // One row of the directed table. A typed row carries its only result as read
  // off by hand. Every other row is checked against the predictor.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  lcis_length_and_traceback #(
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Predictor state. It mirrors the block's sequences, counts, length table and
  // answer buffer, and is only touched when an item is accepted.
  logic signed [31:0] first_seq [MAX_LEN];
  logic signed [31:0] second_seq [MAX_LEN];
  logic signed [31:0] answer_buf [MAX_LEN];
  logic [LEN_W-1:0]   len_tbl [MAX_LEN+1][MAX_LEN+2];
  int                 first_cnt;
  int                 second_cnt;

  // Results caused by the item just accepted, and all results still awaited.
  out_item_t run_results [$];
  out_item_t pending_results [$];

  dir_row_t    dir_rows [$];
  out_item_t   oldest;
  int          mismatches = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  bit          random_phase = 1'b0;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;

  // Works out what one accepted item does to the predictor state and which
  // results it causes. A run fills the table row by row, keeping in k the
  // latest column whose second element equals the current first element, and
  // then walks back from the sentinel column to collect the subsequence.
  task automatic lcis_predict(input in_item_t it);
    int               i, j, k, m, n, pos, len;
    logic [LEN_W-1:0] v, c;
    logic signed [31:0] ai;
    bit               below, sentinel, tracing;
    out_item_t        res;
    run_results.delete();
    case (it.req_type)
      REQ_APPEND_FIRST: begin
        if (first_cnt < MAX_LEN) begin
          first_seq[first_cnt] = it.value;
          first_cnt++;
        end
      end
      REQ_APPEND_SECOND: begin
        if (second_cnt < MAX_LEN) begin
          second_seq[second_cnt] = it.value;
          second_cnt++;
        end
      end
      REQ_RUN: begin
        m = first_cnt;
        n = second_cnt;
        for (i = 0; i <= m; i++) len_tbl[i][0] = '0;
        for (j = 0; j <= n + 1; j++) len_tbl[0][j] = '0;
        for (i = 1; i <= m; i++) begin
          ai = first_seq[i-1];
          k = 0;
          for (j = 1; j <= n + 1; j++) begin
            v = len_tbl[i-1][j];
            sentinel = (j == n + 1);
            // The sentinel column counts as larger than every value.
            if (sentinel) below = 1'b1;
            else below = (ai < second_seq[j-1]);
            if (below && k > 0) begin
              c = len_tbl[i-1][k] + 1'b1;
              if (c > v) v = c;
            end
            len_tbl[i][j] = v;
            if (!sentinel && second_seq[j-1] == ai) k = j;
          end
        end
        len = len_tbl[m][n+1];
        if (len > MAX_LEN) len = MAX_LEN;

        // Walk back: an equal length above means this first element is not
        // used; otherwise match the latest equal second element to the left.
        i = m;
        j = n + 1;
        pos = len;
        tracing = 1'b1;
        while (tracing && i > 0 && len_tbl[i][j] > 0) begin
          if (len_tbl[i][j] == len_tbl[i-1][j]) begin
            i--;
          end else begin
            ai = first_seq[i-1];
            k = j - 1;
            while (k > 0 && second_seq[k-1] != ai) k--;
            if (k == 0 || pos == 0) begin
              tracing = 1'b0;
            end else begin
              pos--;
              answer_buf[pos] = ai;
              i--;
              j = k;
            end
          end
        end

        // The length comes first; it is marked last only for an empty answer.
        res.kind = KIND_LENGTH;
        res.value_res = len;
        res.last = (len == 0);
        run_results.push_back(res);
        for (int e = 0; e < len; e++) begin
          res.kind = KIND_ELEMENT;
          res.value_res = answer_buf[e];
          res.last = (e + 1 == len);
          run_results.push_back(res);
        end
        first_cnt = 0;
        second_cnt = 0;
      end
      default: ;
    endcase
  endtask

  function automatic dir_row_t mk_row(input logic [1:0] req, input logic signed [31:0] val,
                                      input bit typed = 1'b0, input logic kind = KIND_LENGTH,
                                      input logic signed [31:0] res_val = 0,
                                      input logic last = 1'b0);
    dir_row_t row;
    row.item.req_type = req;
    row.item.value = val;
    row.typed = typed;
    row.result.kind = kind;
    row.result.value_res = res_val;
    row.result.last = last;
    return row;
  endfunction

  function automatic logic signed [31:0] pick_value(input int mode, input int idx);
    logic signed [31:0] v;
    case (mode)
      MODE_NARROW: v = $urandom_range(0, 7);
      MODE_SIGNED: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      MODE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = '0;
          3: v = '1;
          default: v = $urandom_range(0, 3);
        endcase
      end
      MODE_RAMP: v = idx * 3 - 40;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Offers one item, optionally after a short idle burst, and holds it until
  // the block takes it. The prediction is made at the edge that accepts it, so
  // the expectations are in place before the first result can come out.
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t typed_res = '0);
    calm = random_phase && (items_sent >= RAND_ITEMS - CALM_ITEMS);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lcis_predict(it);
    if (typed) pending_results.push_back(typed_res);
    else foreach (run_results[r]) pending_results.push_back(run_results[r]);
    if (it.req_type != REQ_UNUSED) items_sent++;
  endtask

  // Loads m first and n second elements in a random interleaving, with the odd
  // ignored item mixed in, and closes the set with a run. Loads beyond the
  // capacity are part of the stimulus and must be dropped by the block.
  task automatic send_set(input int m, input int n, input int mode, input bit hold_at_run);
    in_item_t it;
    int       left_a, left_b;
    left_a = m;
    left_b = n;
    while (left_a + left_b > 0) begin
      if (left_a > 0 && (left_b == 0 || $urandom_range(0, 1) == 1)) begin
        it.req_type = REQ_APPEND_FIRST;
        it.value = pick_value(mode, m - left_a);
        left_a--;
      end else begin
        it.req_type = REQ_APPEND_SECOND;
        it.value = pick_value(mode, n - left_b);
        left_b--;
      end
      send_item(it);
      if ($urandom_range(0, 11) == 0) begin
        it.req_type = REQ_UNUSED;
        it.value = $urandom;
        send_item(it);
      end
    end
    // The receiver starts its long hold-off as this run goes in, while the
    // next set keeps being offered behind it.
    if (hold_at_run) hold_off_req = 1'b1;
    it.req_type = REQ_RUN;
    it.value = $urandom;
    send_item(it);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch: %s", what);
  endtask

  // Result checker. Values are sampled at the edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected item kind=%0d value=%0d last=%0d",
                                out_data.kind, out_data.value_res, out_data.last));
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.kind !== oldest.kind || out_data.value_res !== oldest.value_res ||
            out_data.last !== oldest.last) begin
          note_mismatch($sformatf("expected kind=%0d value=%0d last=%0d, got %0d %0d %0d",
                                  oldest.kind, oldest.value_res, oldest.last,
                                  out_data.kind, out_data.value_res, out_data.last));
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver. Ready drops in random bursts, once for a long hold-off on request,
  // and stays high during the calm end of the run.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender and run control.
  initial begin
    int m, n, mode, set_idx;
    for (int i = 0; i < MAX_LEN; i++) begin
      first_seq[i] = '0;
      second_seq[i] = '0;
      answer_buf[i] = '0;
    end
    first_cnt = 0;
    second_cnt = 0;

    // Directed part. Runs on an empty sequence give a lone zero length, which
    // is marked last; those rows are typed in. The rest cover the value
    // extremes, the ignored request code and ties in the traceback.
    dir_rows = '{
      mk_row(REQ_RUN, 32'sd0, 1'b1, KIND_LENGTH, 0, 1'b1),
      mk_row(REQ_APPEND_FIRST, 32'sd5),
      mk_row(REQ_RUN, 32'sd0, 1'b1, KIND_LENGTH, 0, 1'b1),
      mk_row(REQ_APPEND_SECOND, 32'sd7),
      mk_row(REQ_RUN, '1, 1'b1, KIND_LENGTH, 0, 1'b1),
      mk_row(REQ_APPEND_FIRST, 32'h8000_0000),
      mk_row(REQ_APPEND_FIRST, 32'h7FFF_FFFF),
      mk_row(REQ_APPEND_FIRST, 32'sd0),
      mk_row(REQ_APPEND_SECOND, 32'h8000_0000),
      mk_row(REQ_APPEND_SECOND, 32'sd0),
      mk_row(REQ_APPEND_SECOND, 32'h7FFF_FFFF),
      mk_row(REQ_UNUSED, '1),
      mk_row(REQ_RUN, 32'h7FFF_FFFF),
      mk_row(REQ_APPEND_FIRST, 32'sd3),
      mk_row(REQ_APPEND_FIRST, 32'sd3),
      mk_row(REQ_APPEND_SECOND, 32'sd3),
      mk_row(REQ_APPEND_SECOND, 32'sd3),
      mk_row(REQ_RUN, 32'sd0),
      mk_row(REQ_APPEND_FIRST, 32'sd1),
      mk_row(REQ_APPEND_FIRST, 32'sd2),
      mk_row(REQ_APPEND_SECOND, 32'sd2),
      mk_row(REQ_APPEND_SECOND, 32'sd1),
      mk_row(REQ_RUN, 32'sd0),
      mk_row(REQ_UNUSED, 32'sd0)
    };

    in_valid <= 1'b0;
    in_data <= '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);

    // Random part. The first sets are fixed in shape: an overfilled first
    // sequence, the set behind the long hold-off, a set after which the sender
    // waits for every result, and a full-length increasing match that gives
    // the most results a run can have.
    items_sent = 0;
    random_phase = 1'b1;
    set_idx = 0;
    while (items_sent < RAND_ITEMS) begin
      case (set_idx)
        0: send_set(MAX_LEN + 2, 3, MODE_NARROW, 1'b0);
        1: send_set(12, 12, MODE_NARROW, 1'b1);
        2: begin
          send_set(5, 6, MODE_SIGNED, 1'b0);
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        3: send_set(MAX_LEN, MAX_LEN, MODE_RAMP, 1'b0);
        default: begin
          case ($urandom_range(0, 9))
            0: begin
              m = $urandom_range(0, 1);
              n = $urandom_range(0, 4);
            end
            1: begin
              m = $urandom_range(16, MAX_LEN);
              n = $urandom_range(16, MAX_LEN);
            end
            default: begin
              m = $urandom_range(1, 8);
              n = $urandom_range(1, 8);
            end
          endcase
          if ($urandom_range(0, 5) < 3) mode = MODE_NARROW;
          else mode = $urandom_range(MODE_SIGNED, MODE_EXTREME);
          send_set(m, n, mode, 1'b0);
        end
      endcase
      set_idx++;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
